/* design/sda_pkg.sv */
// Shared constants and types for the stereo downmix averager.
package sda_pkg;

	localparam int SAMPLE_W         = 16;
	localparam int CFG_W            = 4;
	localparam int MAX_CHANNELS_DEF = 8;
	localparam int MIN_CHANNELS     = 2;

	localparam logic [CFG_W-1:0]    CFG_RESET = CFG_W'(2);
	localparam logic [SAMPLE_W-1:0] OUT_LIMIT = SAMPLE_W'(32767);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEFT_GO,
		ST_LEFT_WAIT,
		ST_RIGHT_GO,
		ST_RIGHT_WAIT,
		ST_EMIT
	} sda_state_t;

endpackage

/* design/sda_if.sv */
// Channel interfaces: input samples, output stereo pairs and the config write.
interface sda_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [sda_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface sda_pair_if;
	logic                                valid;
	logic                                ready;
	logic signed [sda_pkg::SAMPLE_W-1:0] left_out;
	logic signed [sda_pkg::SAMPLE_W-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface sda_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [sda_pkg::CFG_W-1:0]      channel_count;

	modport source (output valid, output channel_count, input ready);
	modport sink   (input valid, input channel_count, output ready);
endinterface

/* design/sda_divider.sv */
// Restoring divider, one quotient bit per cycle, unsigned operands.
module sda_divider #(
	parameter int DVD_W = 18,
	parameter int DSR_W = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DSR_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DSR_W:0]   rem_shift;
	logic             fits;

	// quo_q starts as the dividend and fills with quotient bits from the bottom
	assign rem_shift = {rem_q, quo_q[DVD_W-1]};
	assign fits      = rem_shift >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DSR_W'(rem_shift - {1'b0, divisor});
			end else begin
				rem_q <= rem_shift[DSR_W-1:0];
			end
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* design/stereo_downmix_averager.sv */
// Stereo downmix averager: interleaved PCM samples in, averaged stereo pairs out.
//
// Channels: samples (sink) takes one signed 16-bit sample per request; pairs
// (source) delivers one left/right pair per completed frame; cfg (sink) writes
// channel_count and is always ready. Write cfg only while the block is idle.
// Samples at even frame positions go to the left sum, odd ones to the right.
// Values 0 and 1 of channel_count act as 2, values above MAX_CHANNELS as the max.
// A sample that does not end a frame leaves the block idle, so samples stays
// ready. The sample that ends a frame starts the division: one shared
// restoring divider makes one quotient bit per cycle and runs once per side,
// first for the left sum, then for the right (SUM_W = 18 at the default
// MAX_CHANNELS of 8); the pair is then loaded into the output register.
// The quotient is truncated toward zero and clamped to +/-32767.
// The output register lets the next frame accumulate while a pair waits; if the
// receiver still stalls when the following pair is due, the block holds it and
// takes no samples until the register frees.
// Reset clears the sums, the frame position, the output valid flag and sets
// channel_count to 2.
module stereo_downmix_averager #(
	parameter int MAX_CHANNELS = sda_pkg::MAX_CHANNELS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	sda_sample_if.sink    samples,
	sda_pair_if.source    pairs,
	sda_cfg_if.sink       cfg
);

	localparam int SW     = sda_pkg::SAMPLE_W;
	localparam int POS_W  = $clog2(MAX_CHANNELS + 1);
	localparam int PIDX_W = $clog2(MAX_CHANNELS);
	localparam int DIV_W  = POS_W - 1;
	localparam int SUM_W  = SW + $clog2((MAX_CHANNELS + 1) / 2);

	sda_pkg::sda_state_t state_q, state_d;

	logic [sda_pkg::CFG_W-1:0] cfg_q;
	logic [PIDX_W-1:0]         pos_q;
	logic signed [SUM_W-1:0]   left_sum_q;
	logic signed [SUM_W-1:0]   right_sum_q;
	logic signed [SW-1:0]      left_res_q;
	logic signed [SW-1:0]      right_res_q;
	logic                      out_valid_q;
	logic signed [SW-1:0]      left_out_q;
	logic signed [SW-1:0]      right_out_q;

	logic [POS_W-1:0] eff_count;
	logic [DIV_W-1:0] divisor;
	logic [POS_W-1:0] pos_next;
	logic             accept;
	logic             frame_end;
	logic             div_start;
	logic             div_done;
	logic [SUM_W-1:0] div_dividend;
	logic [SUM_W-1:0] div_quotient;
	logic [SUM_W-1:0] left_mag;
	logic [SUM_W-1:0] right_mag;
	logic             out_load;
	logic             out_free;

	// Quotient magnitude and sign back to a clamped signed sample
	function automatic logic [SW-1:0] to_sample(input logic [SUM_W-1:0] mag,
						    input logic neg);
		logic [SW-1:0] lim;
		begin
			lim = (mag > SUM_W'(sda_pkg::OUT_LIMIT)) ? sda_pkg::OUT_LIMIT : SW'(mag);
			to_sample = neg ? SW'(-lim) : lim;
		end
	endfunction

	always_comb begin
		if (int'(cfg_q) > MAX_CHANNELS) begin
			eff_count = POS_W'(MAX_CHANNELS);
		end else if (int'(cfg_q) < sda_pkg::MIN_CHANNELS) begin
			eff_count = POS_W'(sda_pkg::MIN_CHANNELS);
		end else begin
			eff_count = POS_W'(cfg_q);
		end
	end

	assign divisor   = eff_count[POS_W-1:1];
	assign pos_next  = POS_W'(pos_q) + POS_W'(1);
	assign accept    = samples.valid && samples.ready;
	assign frame_end = pos_next >= eff_count;

	assign left_mag  = left_sum_q[SUM_W-1]  ? SUM_W'(-left_sum_q)  : SUM_W'(left_sum_q);
	assign right_mag = right_sum_q[SUM_W-1] ? SUM_W'(-right_sum_q) : SUM_W'(right_sum_q);

	assign out_free = !out_valid_q || pairs.ready;

	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = left_mag;
		out_load     = 1'b0;
		unique case (state_q)
			sda_pkg::ST_IDLE: begin
				if (accept && frame_end) begin
					state_d = sda_pkg::ST_LEFT_GO;
				end
			end
			sda_pkg::ST_LEFT_GO: begin
				div_start = 1'b1;
				state_d   = sda_pkg::ST_LEFT_WAIT;
			end
			sda_pkg::ST_LEFT_WAIT: begin
				if (div_done) begin
					state_d = sda_pkg::ST_RIGHT_GO;
				end
			end
			sda_pkg::ST_RIGHT_GO: begin
				div_start    = 1'b1;
				div_dividend = right_mag;
				state_d      = sda_pkg::ST_RIGHT_WAIT;
			end
			sda_pkg::ST_RIGHT_WAIT: begin
				if (div_done) begin
					state_d = sda_pkg::ST_EMIT;
				end
			end
			sda_pkg::ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = sda_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sda_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= sda_pkg::CFG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			cfg_q <= cfg.channel_count;
		end
	end

	// Sums are held through the division and cleared once the pair is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			left_sum_q  <= '0;
			right_sum_q <= '0;
		end else if (out_load) begin
			left_sum_q  <= '0;
			right_sum_q <= '0;
		end else if (accept) begin
			pos_q <= frame_end ? '0 : PIDX_W'(pos_next);
			if (!pos_q[0]) begin
				left_sum_q <= left_sum_q + SUM_W'(samples.sample);
			end else begin
				right_sum_q <= right_sum_q + SUM_W'(samples.sample);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_done && state_q == sda_pkg::ST_LEFT_WAIT) begin
			left_res_q <= to_sample(div_quotient, left_sum_q[SUM_W-1]);
		end
		if (div_done && state_q == sda_pkg::ST_RIGHT_WAIT) begin
			right_res_q <= to_sample(div_quotient, right_sum_q[SUM_W-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pairs.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			left_out_q  <= left_res_q;
			right_out_q <= right_res_q;
		end
	end

	sda_divider #(
		.DVD_W (SUM_W),
		.DSR_W (DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign samples.ready   = state_q == sda_pkg::ST_IDLE;
	assign cfg.ready       = 1'b1;
	assign pairs.valid     = out_valid_q;
	assign pairs.left_out  = left_out_q;
	assign pairs.right_out = right_out_q;

endmodule
